FILE: src/bthin_pkg.sv
`timescale 1ns / 1ps

package bthin_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int ROW_AW     = $clog2(MAX_HEIGHT);
  localparam int ROW_CW     = $clog2(MAX_HEIGHT + 1);
  localparam int COL_CW     = $clog2(MAX_WIDTH + 1);

  localparam int CFG_WIDTH_W  = 7;
  localparam int CFG_HEIGHT_W = 7;
  localparam int CFG_PASS_W   = 8;
  localparam int CFG_DATA_W   = 8;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT   = 2'd2;

  localparam logic [3:0] NB_LOW  = 4'd1;
  localparam logic [3:0] NB_HIGH = 4'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_FIRST,
    ST_THIN,
    ST_ORD,
    ST_OLOAD
  } bthin_state_t;

  function automatic logic [MAX_WIDTH-1:0] width_mask(input logic [COL_CW-1:0] w);
    logic [MAX_WIDTH-1:0] m;
    for (int x = 0; x < MAX_WIDTH; x++) begin
      m[x] = (COL_CW'(x) < w);
    end
    return m;
  endfunction

  // One subiteration of the thinning rule applied across a whole row.
  function automatic logic [MAX_WIDTH-1:0] thin_row(input logic [MAX_WIDTH-1:0] up,
                                                    input logic [MAX_WIDTH-1:0] cur,
                                                    input logic [MAX_WIDTH-1:0] dn,
                                                    input logic phase);
    logic [MAX_WIDTH+1:0] u;
    logic [MAX_WIDTH+1:0] c;
    logic [MAX_WIDTH+1:0] d;
    logic [MAX_WIDTH-1:0] res;
    logic [7:0] p;
    logic [3:0] cnt;
    logic [3:0] trans;
    logic blocked;
    u   = {1'b0, up, 1'b0};
    c   = {1'b0, cur, 1'b0};
    d   = {1'b0, dn, 1'b0};
    res = cur;
    for (int x = 0; x < MAX_WIDTH; x++) begin
      p[0] = u[x+1];
      p[1] = u[x+2];
      p[2] = c[x+2];
      p[3] = d[x+2];
      p[4] = d[x+1];
      p[5] = d[x];
      p[6] = c[x];
      p[7] = u[x];
      cnt   = 4'd0;
      trans = 4'd0;
      for (int k = 0; k < 8; k++) begin
        cnt = cnt + {3'b000, p[k]};
        if (!p[k] && p[(k+1) & 7]) begin
          trans = trans + 4'd1;
        end
      end
      if (!phase) begin
        blocked = (p[0] & p[2] & p[4]) | (p[2] & p[4] & p[6]);
      end else begin
        blocked = (p[0] & p[2] & p[6]) | (p[0] & p[4] & p[6]);
      end
      if (cur[x] && cnt > NB_LOW && cnt < NB_HIGH && trans == 4'd1 && !blocked) begin
        res[x] = 1'b0;
      end
    end
    return res;
  endfunction

endpackage

FILE: src/bthin_ram.sv
`timescale 1ns / 1ps

module bthin_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/binary_image_thinning.sv
`timescale 1ns / 1ps
// Rows load at one per cycle while idle; the row that completes a frame starts thinning (or output if pass_count is 0).
// Thinning runs pass_count passes of two subiterations over a frame of H rows: one row per
// cycle through the shared row kernel, paced by the single read and write port of the frame RAM.
// Output then reads each row through the ORD and OLOAD states, waiting in ORD while the sink holds
// the pending word; no input is taken from frame completion until the last row is in the output register.
// rst (synchronous) clears control state and sets the registers to 64, 64 and 1; the frame RAM is not cleared.

module binary_image_thinning
  import bthin_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [MAX_WIDTH-1:0]  s_axis_tdata,   // [63:0] row_bits
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [MAX_WIDTH-1:0]  m_axis_tdata,   // [63:0] out_row_bits
  output logic                  m_axis_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  bthin_state_t state, state_next;

  logic [CFG_WIDTH_W-1:0]  frame_width;
  logic [CFG_HEIGHT_W-1:0] frame_height;
  logic [CFG_PASS_W-1:0]   pass_count;

  logic [ROW_CW-1:0]     load_cnt;
  logic [ROW_CW-1:0]     row_idx;
  logic [CFG_PASS_W-1:0] pass_ctr;
  logic                  phase;
  logic [MAX_WIDTH-1:0]  up_row;
  logic [MAX_WIDTH-1:0]  cur_row;
  logic [MAX_WIDTH-1:0]  out_data;
  logic                  out_last;
  logic                  out_valid;

  logic [COL_CW-1:0]    w_eff;
  logic [ROW_CW-1:0]    h_eff;
  logic [MAX_WIDTH-1:0] mask;
  logic [ROW_CW-1:0]    row_inc;
  logic [ROW_CW-1:0]    load_inc;
  logic                 in_acc;
  logic                 out_acc;
  logic                 frame_done;
  logic                 row_last;
  logic                 sub_last;
  logic [MAX_WIDTH-1:0] dn_row;
  logic [MAX_WIDTH-1:0] rd_masked;

  logic                 ram_we;
  logic [ROW_AW-1:0]    ram_waddr;
  logic [MAX_WIDTH-1:0] ram_wdata;
  logic [ROW_AW-1:0]    ram_raddr;
  logic [MAX_WIDTH-1:0] ram_rdata;

  bthin_ram #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (MAX_HEIGHT)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (frame_width == '0) begin
      w_eff = COL_CW'(1);
    end else if (COL_CW'(frame_width) > COL_CW'(MAX_WIDTH)) begin
      w_eff = COL_CW'(MAX_WIDTH);
    end else begin
      w_eff = COL_CW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = ROW_CW'(1);
    end else if (ROW_CW'(frame_height) > ROW_CW'(MAX_HEIGHT)) begin
      h_eff = ROW_CW'(MAX_HEIGHT);
    end else begin
      h_eff = ROW_CW'(frame_height);
    end
  end

  assign mask       = width_mask(w_eff);
  assign rd_masked  = ram_rdata & mask;
  assign row_inc    = row_idx + ROW_CW'(1);
  assign load_inc   = load_cnt + ROW_CW'(1);
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign out_acc    = out_valid && m_axis_tready;
  assign frame_done = (load_inc >= h_eff);
  assign row_last   = (row_inc >= h_eff);
  assign sub_last   = phase && (pass_ctr + CFG_PASS_W'(1) == pass_count);
  assign dn_row     = row_last ? '0 : rd_masked;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && frame_done) begin
          state_next = (pass_count == '0) ? ST_ORD : ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_FIRST;
      ST_FIRST: state_next = ST_THIN;
      ST_THIN: begin
        if (row_last) begin
          state_next = sub_last ? ST_ORD : ST_FETCH;
        end
      end
      ST_ORD: begin
        if (!out_valid || m_axis_tready) begin
          state_next = ST_OLOAD;
        end
      end
      ST_OLOAD: state_next = row_last ? ST_IDLE : ST_ORD;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    ram_we        = 1'b0;
    ram_waddr     = row_idx[ROW_AW-1:0];
    ram_wdata     = thin_row(up_row, cur_row, dn_row, phase);
    ram_raddr     = row_idx[ROW_AW-1:0];
    case (state)
      ST_IDLE: begin
        ram_we    = in_acc;
        ram_waddr = load_cnt[ROW_AW-1:0];
        ram_wdata = s_axis_tdata & mask;
      end
      ST_FETCH: ram_raddr = '0;
      ST_FIRST: ram_raddr = row_inc[ROW_AW-1:0];
      ST_THIN: begin
        ram_we    = 1'b1;
        ram_raddr = ROW_AW'(row_idx + ROW_CW'(2));
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      frame_width  <= CFG_WIDTH_W'(64);
      frame_height <= CFG_HEIGHT_W'(64);
      pass_count   <= CFG_PASS_W'(1);
      load_cnt     <= '0;
      row_idx      <= '0;
      pass_ctr     <= '0;
      phase        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data[CFG_WIDTH_W-1:0];
          REG_FRAME_HEIGHT: frame_height <= cfg_data[CFG_HEIGHT_W-1:0];
          REG_PASS_COUNT:   pass_count   <= cfg_data[CFG_PASS_W-1:0];
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            load_cnt <= frame_done ? '0 : load_inc;
            row_idx  <= '0;
            pass_ctr <= '0;
            phase    <= 1'b0;
          end
        end
        ST_THIN: begin
          row_idx <= row_last ? '0 : row_inc;
          if (row_last) begin
            phase <= ~phase;
            if (phase) begin
              pass_ctr <= pass_ctr + CFG_PASS_W'(1);
            end
          end
        end
        ST_OLOAD: row_idx <= row_last ? '0 : row_inc;
        default: ;
      endcase
      if (state == ST_OLOAD) begin
        out_valid <= 1'b1;
      end else if (out_acc) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_FETCH: up_row <= '0;
      ST_FIRST: cur_row <= rd_masked;
      ST_THIN: begin
        up_row  <= cur_row;
        cur_row <= dn_row;
      end
      ST_OLOAD: begin
        out_data <= rd_masked;
        out_last <= row_last;
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;

  a_ram_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_IDLE || state == ST_THIN))
    else $error("frame RAM written outside load or thinning");

  a_out_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OLOAD) |-> !out_valid)
    else $error("output word overwritten while pending");

  a_thin_row_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_THIN) |-> (row_idx < h_eff))
    else $error("thinning row beyond frame height");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OLOAD && row_last) |=> (state == ST_IDLE && m_axis_tlast))
    else $error("final row did not return to idle");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bthin_pkg::*;

  localparam int LIMIT_CYCLES  = 3000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int RAND_ROWS     = 400;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {
    ROW_NOISE,
    ROW_BLOCK,
    ROW_BAND
  } row_style_t;

  typedef struct {
    logic [MAX_WIDTH-1:0] bits;
    logic                 last;
  } thinned_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [MAX_WIDTH-1:0]  s_axis_tdata = '0;   // [63:0] row_bits
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [MAX_WIDTH-1:0]  m_axis_tdata;        // [63:0] out_row_bits
  logic                  m_axis_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  binary_image_thinning u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  logic [MAX_WIDTH-1:0] pending_rows[$];
  thinned_row_t         thinned_q[$];
  thinned_row_t         exp_row;

  logic [CFG_WIDTH_W-1:0]  cfg_w = 7'd64;
  logic [CFG_HEIGHT_W-1:0] cfg_h = 7'd64;
  logic [CFG_PASS_W-1:0]   cfg_passes = 8'd1;
  logic [MAX_WIDTH-1:0]    frame_img[MAX_HEIGHT];
  int unsigned             rows_loaded = 0;

  int  errors = 0;
  int  rows_sent = 0;
  int  frames_done = 0;
  int  rows_checked = 0;
  int  reg_writes = 0;
  int  cycles = 0;
  int  send_idle = 27;
  int  recv_idle = 57;
  int  hold_left = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;

  function automatic int unsigned eff_w();
    int unsigned w;
    w = cfg_w;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned eff_h();
    int unsigned h;
    h = cfg_h;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic logic [MAX_WIDTH-1:0] row_mask(input int unsigned w);
    logic [MAX_WIDTH-1:0] one;
    one = 1;
    return (w >= MAX_WIDTH) ? '1 : ((one << w) - 1);
  endfunction

  function automatic bit px(input logic [MAX_WIDTH-1:0] row, input int x);
    if (x < 0 || x >= MAX_WIDTH) return 1'b0;
    return row[x];
  endfunction

  function automatic logic [MAX_WIDTH-1:0] thin_one_row(input logic [MAX_WIDTH-1:0] up,
                                                        input logic [MAX_WIDTH-1:0] cur,
                                                        input logic [MAX_WIDTH-1:0] dn,
                                                        input int unsigned w,
                                                        input bit second);
    logic [MAX_WIDTH-1:0] res;
    bit [7:0] nb;
    int cnt;
    int trans;
    bit blocked;
    res = cur;
    for (int x = 0; x < int'(w); x++) begin
      if (cur[x]) begin
        // ring order N, NE, E, SE, S, SW, W, NW
        nb[0] = px(up, x);
        nb[1] = px(up, x + 1);
        nb[2] = px(cur, x + 1);
        nb[3] = px(dn, x + 1);
        nb[4] = px(dn, x);
        nb[5] = px(dn, x - 1);
        nb[6] = px(cur, x - 1);
        nb[7] = px(up, x - 1);
        cnt = $countones(nb);
        trans = 0;
        for (int k = 0; k < 8; k++) begin
          if (!nb[k] && nb[(k + 1) % 8]) trans++;
        end
        if (!second) begin
          blocked = (nb[0] & nb[2] & nb[4]) | (nb[2] & nb[4] & nb[6]);
        end else begin
          blocked = (nb[0] & nb[2] & nb[6]) | (nb[0] & nb[4] & nb[6]);
        end
        if (cnt > int'(NB_LOW) && cnt < int'(NB_HIGH) && trans == 1 && !blocked) begin
          res[x] = 1'b0;
        end
      end
    end
    return res;
  endfunction

  function automatic void absorb_row(input logic [MAX_WIDTH-1:0] row);
    int unsigned w;
    int unsigned h;
    logic [MAX_WIDTH-1:0] m;
    logic [MAX_WIDTH-1:0] up;
    logic [MAX_WIDTH-1:0] cur;
    logic [MAX_WIDTH-1:0] nxt;
    thinned_row_t t;
    w = eff_w();
    h = eff_h();
    m = row_mask(w);
    if (rows_loaded < MAX_HEIGHT) frame_img[rows_loaded] = row & m;
    rows_loaded++;
    if (rows_loaded >= h) begin
      for (int y = 0; y < int'(h); y++) frame_img[y] &= m;
      for (int p = 0; p < int'(cfg_passes); p++) begin
        for (int ph = 0; ph < 2; ph++) begin
          up = '0;
          for (int y = 0; y < int'(h); y++) begin
            nxt = (y + 1 < int'(h)) ? frame_img[y + 1] : '0;
            cur = frame_img[y];
            frame_img[y] = thin_one_row(up, cur, nxt, w, ph[0]);
            up = cur;
          end
        end
      end
      for (int y = 0; y < int'(h); y++) begin
        t.bits = frame_img[y] & m;
        t.last = (y + 1 == int'(h));
        thinned_q.insert(thinned_q.size(), t);
      end
      rows_loaded = 0;
      frames_done++;
    end
  endfunction

  function automatic logic [MAX_WIDTH-1:0] make_row(input row_style_t st, input int y,
                                                    input int off);
    int w;
    int lo;
    int hi;
    logic [MAX_WIDTH-1:0] m;
    logic [MAX_WIDTH-1:0] one;
    logic [MAX_WIDTH-1:0] r;
    w = eff_w();
    m = row_mask(w);
    one = 1;
    case (st)
      ROW_NOISE: begin
        r = {$urandom, $urandom};
      end
      ROW_BLOCK: begin
        lo = $urandom_range(w / 4, 0);
        hi = lo + $urandom_range(w - 1 - lo, (w - 1 - lo) / 2);
        r = ((one << (hi - lo + 1)) - 1) << lo;
        if ($urandom_range(3) == 0) r &= ~(one << $urandom_range(w - 1, 0));
      end
      default: begin
        lo = (y + off) % w;
        hi = lo + $urandom_range(5, 2);
        if (hi > w - 1) hi = w - 1;
        r = ((one << (hi - lo + 1)) - 1) << lo;
      end
    endcase
    // junk above the frame width must vanish
    return (r & m) | ({$urandom, $urandom} & ~m);
  endfunction

  task automatic queue_row(input logic [MAX_WIDTH-1:0] r);
    pending_rows.insert(pending_rows.size(), r);
  endtask

  task automatic push_rows(input row_style_t st, input int n);
    int off;
    off = $urandom_range(63);
    for (int y = 0; y < n; y++) queue_row(make_row(st, y, off));
  endtask

  task automatic settle();
    while (pending_rows.size() != 0 || s_axis_tvalid || thinned_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_FRAME_WIDTH:  cfg_w = val[CFG_WIDTH_W-1:0];
      REG_FRAME_HEIGHT: cfg_h = val[CFG_HEIGHT_W-1:0];
      REG_PASS_COUNT:   cfg_passes = val[CFG_PASS_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic set_frame(input logic [7:0] w, input logic [7:0] h, input logic [7:0] p);
    settle();
    put_reg(REG_FRAME_WIDTH, w);
    put_reg(REG_FRAME_HEIGHT, h);
    put_reg(REG_PASS_COUNT, p);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_row(pending_rows.pop_front());
        rows_sent++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (pending_rows.size() != 0 && int'($urandom_range(99)) >= send_idle) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_rows[0];
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (thinned_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word %h last %b", $time, m_axis_tdata, m_axis_tlast);
        end else begin
          exp_row = thinned_q.pop_front();
          rows_checked++;
          if (m_axis_tdata !== exp_row.bits) begin
            errors++;
            $display("%0t: row mismatch: expected %h, got %h", $time, exp_row.bits,
                     m_axis_tdata);
          end
          if (m_axis_tlast !== exp_row.last) begin
            errors++;
            $display("%0t: tlast mismatch: expected %b, got %b", $time, exp_row.last,
                     m_axis_tlast);
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (int'($urandom_range(99)) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int rand_rows;
    int nframes;
    int k;
    int left;
    logic [7:0] wv;
    logic [7:0] hv;
    logic [7:0] pv;
    row_style_t st;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full-width solid frame, then edge bits and alternating pixels
    set_frame(8'd64, 8'd3, 8'd1);
    repeat (3) queue_row('1);
    queue_row('0);
    queue_row(64'h8000_0000_0000_0001);
    queue_row(64'h5555_5555_5555_5555);

    // width above range, height of zero
    set_frame(8'd127, 8'd0, 8'd1);
    queue_row('1);

    // width of zero, no passes
    set_frame(8'd0, 8'd2, 8'd0);
    repeat (2) queue_row('1);

    // small diamond shape, maximum pass count
    set_frame(8'd5, 8'd5, 8'd255);
    queue_row(64'hA5A5_FFFF_0000_0FE4);
    queue_row(64'h0000_0000_0000_002E);
    queue_row(64'hFFFF_FFFF_FFFF_FFFF);
    queue_row(64'h1234_5678_9ABC_DEEE);
    queue_row(64'h0000_0000_0000_0004);

    // shrink width and height while a frame is partly loaded
    set_frame(8'd16, 8'd8, 8'd2);
    put_reg(REG_UNUSED, 8'($urandom_range(255)));
    cfg_we <= 1'b0;
    push_rows(ROW_BLOCK, 3);
    settle();
    put_reg(REG_FRAME_WIDTH, 8'd8);
    put_reg(REG_FRAME_HEIGHT, 8'd2);
    cfg_we <= 1'b0;
    push_rows(ROW_BLOCK, 1);

    // top bits of the register data are dropped
    set_frame(8'd255, 8'd130, 8'd3);
    push_rows(ROW_BAND, 2);

    rand_rows = 0;
    while (rand_rows < RAND_ROWS) begin
      case ($urandom_range(9))
        0:       wv = 8'd1;
        1:       wv = 8'd64;
        2:       wv = 8'($urandom_range(255));
        default: wv = 8'($urandom_range(64, 3));
      endcase
      case ($urandom_range(11))
        0:       hv = 8'd64;
        1:       hv = 8'($urandom_range(255));
        2:       hv = 8'($urandom_range(2, 0));
        default: hv = 8'($urandom_range(8, 3));
      endcase
      settle();
      put_reg(REG_FRAME_WIDTH, wv);
      put_reg(REG_FRAME_HEIGHT, hv);
      if (eff_h() <= 8 && $urandom_range(19) == 0) pv = 8'($urandom_range(255, 4));
      else if ($urandom_range(9) == 0) pv = 8'd0;
      else pv = 8'($urandom_range(3, 1));
      put_reg(REG_PASS_COUNT, pv);
      cfg_we <= 1'b0;

      nframes = (eff_h() == MAX_HEIGHT) ? 1 : $urandom_range(3, 1);
      if (rand_rows == 0) begin
        nframes = 3;
        hold_req = 1'b1;
      end
      for (int f = 0; f < nframes; f++) begin
        case ($urandom_range(3))
          0:       st = ROW_NOISE;
          1:       st = ROW_BAND;
          default: st = ROW_BLOCK;
        endcase
        if ($urandom_range(9) == 0 && eff_h() > 2) begin
          k = $urandom_range(eff_h() - 1, 1);
          push_rows(st, k);
          settle();
          put_reg(REG_FRAME_HEIGHT, 8'($urandom_range(12, 0)));
          cfg_we <= 1'b0;
          left = (k + 1 >= int'(eff_h())) ? 1 : int'(eff_h()) - k;
          push_rows(st, left);
          rand_rows += k + left;
        end else begin
          push_rows(st, eff_h());
          rand_rows += eff_h();
        end
        if (rand_rows < RAND_ROWS / 3) begin
          send_idle = 27;
          recv_idle = 57;
        end else if (rand_rows < 2 * RAND_ROWS / 3) begin
          send_idle = 57;
          recv_idle = 27;
        end else begin
          send_idle = 0;
          recv_idle = 0;
        end
        if (rand_rows >= RAND_ROWS) break;
      end
    end

    settle();
    repeat (40) @(posedge clk);
    errors += thinned_q.size();
    $display("Sent %0d rows in %0d frames over %0d register writes; checked %0d rows, %0d errors.",
             rows_sent, frames_done, reg_writes, rows_checked, errors);
    $display("Widths and heights 0 to 127, passes 0 to 255, mid-frame resize, long output stall.");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/bthin_pkg.sv
src/bthin_ram.sv
src/binary_image_thinning.sv
dv/testbench.sv
